>>> rtl/hsv2rgb_pkg.sv
// hsv2rgb_pkg: types, constants and fixed-point helpers for the hsv to rgb converter
package hsv2rgb_pkg;

  // number format: unsigned, FracBits fraction bits, One means 1.0
  localparam int FracBits = 16;
  localparam int FixW     = FracBits + 1;
  localparam int H6W      = FracBits + 3;
  localparam int ChanW    = 8;

  localparam logic [FixW-1:0] One      = FixW'(1) << FracBits;
  localparam logic [ChanW:0]  ChanFull = (ChanW + 1)'(255);

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_e;

  typedef struct packed {
    logic [FixW-1:0] hue;
    logic [FixW-1:0] saturation;
    logic [FixW-1:0] brightness;
  } hsv_pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_pixel_t;

  // saturate a value to one
  function automatic logic [FixW-1:0] clamp_one(input logic [FixW-1:0] x);
    clamp_one = (x > One) ? One : x;
  endfunction

  // fixed-point product of two values in 0..One, result in 0..One
  function automatic logic [FixW-1:0] mul_fx(input logic [FixW-1:0] a,
                                             input logic [FixW-1:0] b);
    logic [2*FixW-1:0] prod;
    prod   = (2*FixW)'(a) * (2*FixW)'(b);
    mul_fx = prod[FracBits +: FixW];
  endfunction

  // scale a value in 0..One to a channel byte, truncating
  function automatic logic [ChanW-1:0] to_byte(input logic [FixW-1:0] x);
    logic [FixW+ChanW:0] prod;
    prod    = (FixW + ChanW + 1)'(x) * (FixW + ChanW + 1)'(ChanFull);
    to_byte = prod[FracBits +: ChanW];
  endfunction

endpackage

>>> rtl/hsv_to_rgb_converter.sv
// hsv_to_rgb_converter: four-stage pipeline from hsv pixels to 8-bit rgb
// Each accepted word is registered in stage 1, 2, 3 and 4 in turn and leaves from stage 4.
// One pixel per cycle unless stalled; each stage holds one word and has its own valid bit.
// Stage depth is set by one 17x17 multiplier per product (three in stage 2, two in stage 3).
// Reset clears all stage valid bits; payload registers are not reset.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  hsv_pixel_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rgb_pixel_t out_data_o
);

  // stage valid bits and ready chain
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready   = !s4_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
      if (s4_ready) s4_valid_q <= s3_valid_q;
    end
  end

  // stage 1: clamp, wrap hue, split six times hue into sector and fraction
  logic [FixW-1:0]     hue_w;
  logic [H6W-1:0]      h6_w;
  logic [FixW-1:0]     s1_sat_d, s1_bri_d;
  logic [FracBits-1:0] s1_frac_d;
  sector_e             s1_sec_d;

  always_comb begin
    hue_w     = (in_data_i.hue >= One) ? '0 : in_data_i.hue;
    h6_w      = H6W'(hue_w) * H6W'(6);
    s1_sec_d  = sector_e'(h6_w[FracBits +: 3]);
    s1_frac_d = h6_w[FracBits-1:0];
    s1_sat_d  = clamp_one(in_data_i.saturation);
    s1_bri_d  = clamp_one(in_data_i.brightness);
  end

  logic [FixW-1:0]     s1_sat_q, s1_bri_q;
  logic [FracBits-1:0] s1_frac_q;
  sector_e             s1_sec_q;

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_sat_q  <= s1_sat_d;
      s1_bri_q  <= s1_bri_d;
      s1_frac_q <= s1_frac_d;
      s1_sec_q  <= s1_sec_d;
    end
  end

  // stage 2: s*f, s*(1-f) and v*(1-s)
  logic [FixW-1:0] frac_w, s2_sf_d, s2_sg_d, s2_p1_d;

  always_comb begin
    frac_w  = FixW'(s1_frac_q);
    s2_sf_d = mul_fx(s1_sat_q, frac_w);
    s2_sg_d = mul_fx(s1_sat_q, One - frac_w);
    s2_p1_d = mul_fx(s1_bri_q, One - s1_sat_q);
  end

  logic [FixW-1:0] s2_sf_q, s2_sg_q, s2_p1_q, s2_bri_q;
  sector_e         s2_sec_q;

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_sf_q  <= s2_sf_d;
      s2_sg_q  <= s2_sg_d;
      s2_p1_q  <= s2_p1_d;
      s2_bri_q <= s1_bri_q;
      s2_sec_q <= s1_sec_q;
    end
  end

  // stage 3: v*(1-s*f) and v*(1-s*(1-f))
  logic [FixW-1:0] s3_p2_d, s3_p3_d;

  always_comb begin
    s3_p2_d = mul_fx(s2_bri_q, One - s2_sf_q);
    s3_p3_d = mul_fx(s2_bri_q, One - s2_sg_q);
  end

  logic [FixW-1:0] s3_p1_q, s3_p2_q, s3_p3_q, s3_bri_q;
  sector_e         s3_sec_q;

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_p1_q  <= s2_p1_q;
      s3_p2_q  <= s3_p2_d;
      s3_p3_q  <= s3_p3_d;
      s3_bri_q <= s2_bri_q;
      s3_sec_q <= s2_sec_q;
    end
  end

  // stage 4: sector picks the source of each channel, then scale to a byte
  logic [FixW-1:0] r_w, g_w, b_w;
  rgb_pixel_t      s4_data_d;

  always_comb begin
    unique case (s3_sec_q)
      SECTOR_0: begin
        r_w = s3_bri_q; g_w = s3_p3_q;  b_w = s3_p1_q;
      end
      SECTOR_1: begin
        r_w = s3_p2_q;  g_w = s3_bri_q; b_w = s3_p1_q;
      end
      SECTOR_2: begin
        r_w = s3_p1_q;  g_w = s3_bri_q; b_w = s3_p3_q;
      end
      SECTOR_3: begin
        r_w = s3_p1_q;  g_w = s3_p2_q;  b_w = s3_bri_q;
      end
      SECTOR_4: begin
        r_w = s3_p3_q;  g_w = s3_p1_q;  b_w = s3_bri_q;
      end
      default: begin
        r_w = s3_bri_q; g_w = s3_p1_q;  b_w = s3_p2_q;
      end
    endcase
    s4_data_d.red   = to_byte(r_w);
    s4_data_d.green = to_byte(g_w);
    s4_data_d.blue  = to_byte(b_w);
  end

  rgb_pixel_t s4_data_q;

  always_ff @(posedge clk_i) begin
    if (s4_ready && s3_valid_q) begin
      s4_data_q <= s4_data_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign out_data_o  = s4_data_q;

endmodule

>>> rtl/hsv2rgb_checker.sv
// hsv2rgb_checker: port-level assertions for the hsv to rgb converter, with its bind
module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input hsv_pixel_t in_data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input rgb_pixel_t out_data_o
);

  // a stalled result word stays and holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // input side only backs up when the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without an output stall");

  // nothing comes out at the first edge after reset
  assert property (@(posedge clk_i)
    rst_ni && $past(!rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // an idle output means the pipeline can take a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready while output is empty");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
